@@ hw/rtl/tppr_pkg.sv @@
package tppr_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam logic [15:0] PKT_SAT = 16'hFFFF;

    localparam logic [2:0] REG_PATTERN_A     = 3'd0;
    localparam logic [2:0] REG_PATTERN_A_LEN = 3'd1;
    localparam logic [2:0] REG_REPLACE_A     = 3'd2;
    localparam logic [2:0] REG_PATTERN_B     = 3'd3;
    localparam logic [2:0] REG_PATTERN_B_LEN = 3'd4;
    localparam logic [2:0] REG_REPLACE_B     = 3'd5;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_REC  = 1'b1;

    localparam logic [31:0] TCP_PROTO = 32'd6;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] csum;
        logic        changed;
        logic        last;
    } out_item_t;

endpackage

@@ hw/rtl/tppr_stage.sv @@
module tppr_stage #(
    parameter int PATTERN_MAX = tppr_pkg::PATTERN_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] pattern,
    input  logic [3:0]  pattern_len,
    input  logic [63:0] replace,
    input  logic [6:0]  pay_start,
    input  logic [15:0] total_len,
    input  logic        clear,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        in_ready,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        out_last,
    input  logic        out_take,
    output logic        found
);

    localparam int FW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0]    cells_reg [PATTERN_MAX];
    logic [7:0]    sh        [PATTERN_MAX];
    logic [7:0]    repc      [PATTERN_MAX];
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic          found_reg;
    logic          flush_reg;
    logic          flush_next;
    logic [15:0]   pos_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic [FW-1:0] len_eff;
    logic [FW-1:0] limit;
    logic [FW-1:0] fill_p;
    logic [FW-1:0] fill_m;
    logic [FW-1:0] lim_p;
    logic          space;
    logic          drain;
    logic          push;
    logic          pop_only;
    logic          do_pop;
    logic          last_tag;
    logic [7:0]    pop_byte;
    logic          match;
    logic          hit;
    logic          pay_ok;
    logic [16:0]   p1;
    logic [16:0]   lenx;
    logic [3:0]    idx;

    always_comb
    begin
        len_eff = (pattern_len > 4'(PATTERN_MAX)) ? FW'(PATTERN_MAX) : FW'(pattern_len);
        limit = (len_eff == '0) ? '0 : len_eff - FW'(1);
        space = !out_valid_reg || out_take;
        drain = flush_reg ? (fill_reg != '0) : (fill_reg > limit);
        in_ready = space && !drain && !flush_reg;
        push = in_valid && in_ready;
        pop_only = space && drain;
        fill_p = fill_reg + FW'(1);
        fill_m = fill_reg - FW'(1);

        p1 = {1'b0, pos_reg} + 17'd1;
        lenx = 17'(len_eff);
        pay_ok = (p1 >= lenx) && ((p1 - lenx) >= 17'(pay_start)) && (pos_reg < total_len);

        sh[0] = in_byte;
        for (int j = 1; j < PATTERN_MAX; j++)
        begin
            sh[j] = cells_reg[j-1];
        end

        match = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            idx = 4'(len_eff) - 4'(1) - 4'(j);
            if (FW'(j) < len_eff && sh[j] != pattern[{idx[2:0], 3'b000} +: 8])
            begin
                match = 1'b0;
            end
        end
        idx = '0;

        hit = push && (len_eff != '0) && (fill_p >= len_eff) && !found_reg && pay_ok && match;

        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            idx = 4'(len_eff) - 4'(1) - 4'(j);
            repc[j] = (hit && FW'(j) < len_eff) ? replace[{idx[2:0], 3'b000} +: 8] : sh[j];
        end

        lim_p = in_last ? '0 : limit;
        do_pop = 1'b0;
        fill_next = fill_reg;
        flush_next = flush_reg;
        last_tag = 1'b0;
        pop_byte = repc[fill_reg[IW-1:0]];
        if (push)
        begin
            do_pop = fill_p > lim_p;
            fill_next = do_pop ? fill_reg : fill_p;
            flush_next = in_last && (fill_next != '0);
            last_tag = in_last && (fill_next == '0);
        end
        else if (pop_only)
        begin
            do_pop = 1'b1;
            pop_byte = cells_reg[fill_m[IW-1:0]];
            fill_next = fill_m;
            flush_next = flush_reg && (fill_m != '0);
            last_tag = flush_reg && (fill_m == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            found_reg <= 1'b0;
            flush_reg <= 1'b0;
            pos_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            flush_reg <= flush_next;
            if (clear)
            begin
                found_reg <= 1'b0;
                pos_reg <= '0;
            end
            else if (push)
            begin
                found_reg <= found_reg || hit;
                pos_reg <= (pos_reg < tppr_pkg::PKT_SAT) ? pos_reg + 16'd1 : pos_reg;
            end
            if (do_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                cells_reg[j] <= repc[j];
            end
        end
        if (do_pop)
        begin
            out_byte_reg <= pop_byte;
            out_last_reg <= last_tag;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;
    assign found = found_reg;

endmodule

@@ hw/rtl/tppr_out_fifo.sv @@
module tppr_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tppr_pkg::out_item_t push_item,
    output logic                space,
    output logic                out_valid,
    input  logic                out_stall,
    output tppr_pkg::out_item_t head
);

    tppr_pkg::out_item_t e0_reg;
    tppr_pkg::out_item_t e1_reg;
    logic [1:0]          count_reg;
    logic                pop;

    assign out_valid = count_reg != 2'd0;
    assign space = count_reg != 2'd2;
    assign pop = out_valid && !out_stall;
    assign head = e0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e0_reg <= (push && count_reg == 2'd1) ? push_item : e1_reg;
            if (push && count_reg == 2'd2)
            begin
                e1_reg <= push_item;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                e0_reg <= push_item;
            end
            else
            begin
                e1_reg <= push_item;
            end
        end
    end

endmodule

@@ hw/rtl/tcp_payload_pattern_rewriter.sv @@
// Stage A holds back len_a-1 bytes and stage B len_b-1. Throughput: one byte per
// cycle while out_stall is low and no record is pending; each chain advances one
// byte per push. A packet's last byte flushes both chains, then ST_SUM and ST_REC
// build the checksum record; input stalls from the last byte until it is queued.
// Reset (rst_n low, asynchronous) clears registers, chains and the output queue.
module tcp_payload_pattern_rewriter #(
    parameter int PATTERN_MAX = tppr_pkg::PATTERN_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pkt_byte,
    input  logic        pkt_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        rec_kind,
    output logic [7:0]  out_byte,
    output logic [15:0] new_checksum,
    output logic        was_changed,
    output logic        rec_last
);

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_SUM = 2'd1;
    localparam logic [1:0] ST_REC = 2'd2;

    logic [63:0] pattern_a_reg;
    logic [3:0]  pattern_a_len_reg;
    logic [63:0] replace_a_reg;
    logic [63:0] pattern_b_reg;
    logic [3:0]  pattern_b_len_reg;
    logic [63:0] replace_b_reg;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic        busy_reg;
    logic [15:0] pos_reg;
    logic [3:0]  ihl_reg;
    logic [3:0]  tcp_reg;
    logic [15:0] total_reg;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [7:0]  hold_reg;
    logic [15:0] ocount_reg;
    logic [31:0] sum_reg;

    logic [3:0]  ihl_eff;
    logic [3:0]  tcp_eff;
    logic [5:0]  hdr;
    logic [6:0]  pay;
    logic [15:0] h16;
    logic        accept;
    logic        a_in_ready;
    logic        a_out_valid;
    logic [7:0]  a_out_byte;
    logic        a_out_last;
    logic        a_found;
    logic        b_in_ready;
    logic        b_out_valid;
    logic [7:0]  b_out_byte;
    logic        b_out_last;
    logic        b_found;
    logic        take_a;
    logic        take_b;
    logic        clear;
    logic        fifo_space;
    logic        fifo_push;
    tppr_pkg::out_item_t push_item;
    tppr_pkg::out_item_t head;

    logic [15:0] k;
    logic        in_seg;
    logic [7:0]  c;
    logic [31:0] hdr_add;
    logic [31:0] emit_add;
    logic [15:0] n;
    logic [15:0] nh;
    logic [31:0] pad;
    logic [31:0] seg;
    logic [16:0] f1;
    logic [16:0] f2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_a_reg <= '0;
            pattern_a_len_reg <= '0;
            replace_a_reg <= '0;
            pattern_b_reg <= '0;
            pattern_b_len_reg <= '0;
            replace_b_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tppr_pkg::REG_PATTERN_A:     pattern_a_reg <= cfg_data;
                tppr_pkg::REG_PATTERN_A_LEN: pattern_a_len_reg <= cfg_data[3:0];
                tppr_pkg::REG_REPLACE_A:     replace_a_reg <= cfg_data;
                tppr_pkg::REG_PATTERN_B:     pattern_b_reg <= cfg_data;
                tppr_pkg::REG_PATTERN_B_LEN: pattern_b_len_reg <= cfg_data[3:0];
                tppr_pkg::REG_REPLACE_B:     replace_b_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    assign ihl_eff = (ihl_reg < 4'd5) ? 4'd5 : ihl_reg;
    assign tcp_eff = (tcp_reg < 4'd5) ? 4'd5 : tcp_reg;
    assign hdr = {ihl_eff, 2'b00};
    assign pay = 7'(hdr) + {1'b0, tcp_eff, 2'b00};
    assign h16 = 16'(hdr);

    assign in_stall = busy_reg || !a_in_ready;
    assign accept = in_valid && !in_stall;
    assign take_a = a_out_valid && b_in_ready;
    assign take_b = b_out_valid && fifo_space && (state_reg == ST_RUN);
    assign clear = (state_reg == ST_REC) && fifo_space;

    tppr_stage #(.PATTERN_MAX(PATTERN_MAX)) u_stage_a (
        .clk         (clk),
        .rst_n       (rst_n),
        .pattern     (pattern_a_reg),
        .pattern_len (pattern_a_len_reg),
        .replace     (replace_a_reg),
        .pay_start   (pay),
        .total_len   (total_reg),
        .clear       (clear),
        .in_valid    (in_valid && !busy_reg),
        .in_byte     (pkt_byte),
        .in_last     (pkt_last),
        .in_ready    (a_in_ready),
        .out_valid   (a_out_valid),
        .out_byte    (a_out_byte),
        .out_last    (a_out_last),
        .out_take    (take_a),
        .found       (a_found)
    );

    tppr_stage #(.PATTERN_MAX(PATTERN_MAX)) u_stage_b (
        .clk         (clk),
        .rst_n       (rst_n),
        .pattern     (pattern_b_reg),
        .pattern_len (pattern_b_len_reg),
        .replace     (replace_b_reg),
        .pay_start   (pay),
        .total_len   (total_reg),
        .clear       (clear),
        .in_valid    (a_out_valid),
        .in_byte     (a_out_byte),
        .in_last     (a_out_last),
        .in_ready    (b_in_ready),
        .out_valid   (b_out_valid),
        .out_byte    (b_out_byte),
        .out_last    (b_out_last),
        .out_take    (take_b),
        .found       (b_found)
    );

    always_comb
    begin
        k = ocount_reg - h16;
        in_seg = (ocount_reg >= h16) && (ocount_reg < total_reg);
        c = (k == 16'd16 || k == 16'd17) ? 8'd0 : b_out_byte;
        emit_add = (take_b && in_seg && k[0]) ? {16'd0, hold_reg, c} : 32'd0;
        hdr_add = 32'd0;
        if (accept && pos_reg >= 16'd12 && pos_reg <= 16'd19)
        begin
            hdr_add = pos_reg[0] ? {24'd0, pkt_byte} : {16'd0, pkt_byte, 8'd0};
        end
        acc_next = acc_reg + hdr_add + emit_add;

        n = (ocount_reg < total_reg) ? ocount_reg : total_reg;
        nh = n - h16;
        pad = (n > h16 && nh[0]) ? {16'd0, hold_reg, 8'd0} : 32'd0;
        seg = (total_reg > h16) ? {16'd0, total_reg - h16} : 32'd0;

        f1 = {1'b0, sum_reg[31:16]} + {1'b0, sum_reg[15:0]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};

        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:  if (take_b && b_out_last) state_next = ST_SUM;
            ST_SUM:  state_next = ST_REC;
            ST_REC:  if (fifo_space) state_next = ST_RUN;
            default: state_next = ST_RUN;
        endcase

        fifo_push = take_b || clear;
        push_item.kind = clear ? tppr_pkg::KIND_REC : tppr_pkg::KIND_BYTE;
        push_item.data = clear ? 8'd0 : b_out_byte;
        push_item.csum = clear ? ~f2[15:0] : 16'd0;
        push_item.changed = clear && (a_found || b_found);
        push_item.last = clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            busy_reg <= 1'b0;
            pos_reg <= '0;
            ihl_reg <= '0;
            tcp_reg <= '0;
            total_reg <= '0;
            acc_reg <= '0;
            hold_reg <= '0;
            ocount_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SUM)
            begin
                sum_reg <= acc_reg + pad + tppr_pkg::TCP_PROTO + seg;
            end
            if (clear)
            begin
                busy_reg <= 1'b0;
                pos_reg <= '0;
                ihl_reg <= '0;
                tcp_reg <= '0;
                total_reg <= '0;
                acc_reg <= '0;
                hold_reg <= '0;
                ocount_reg <= '0;
            end
            else
            begin
                acc_reg <= acc_next;
                if (accept)
                begin
                    busy_reg <= pkt_last;
                    pos_reg <= (pos_reg < tppr_pkg::PKT_SAT) ? pos_reg + 16'd1 : pos_reg;
                    if (pos_reg == 16'd0)
                    begin
                        ihl_reg <= pkt_byte[3:0];
                    end
                    if (pos_reg == 16'd2)
                    begin
                        total_reg[15:8] <= pkt_byte;
                    end
                    if (pos_reg == 16'd3)
                    begin
                        total_reg[7:0] <= pkt_byte;
                    end
                    if (pos_reg == h16 + 16'd12)
                    begin
                        tcp_reg <= pkt_byte[7:4];
                    end
                end
                if (take_b)
                begin
                    ocount_reg <= (ocount_reg < tppr_pkg::PKT_SAT) ? ocount_reg + 16'd1
                                                                   : ocount_reg;
                    if (in_seg && !k[0])
                    begin
                        hold_reg <= c;
                    end
                end
            end
        end
    end

    tppr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_item (push_item),
        .space     (fifo_space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign rec_kind = head.kind;
    assign out_byte = head.data;
    assign new_checksum = head.csum;
    assign was_changed = head.changed;
    assign rec_last = head.last;

endmodule

@@ hw/rtl/tppr_checker.sv @@
module tppr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        pkt_last,
    input logic        out_valid,
    input logic        out_stall,
    input logic        rec_kind,
    input logic [7:0]  out_byte,
    input logic [15:0] new_checksum,
    input logic        was_changed,
    input logic        rec_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_byte) && $stable(new_checksum)
            && $stable(rec_kind))
        else $error("stalled output item changed");

    a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rec_kind == tppr_pkg::KIND_BYTE |->
            new_checksum == 16'd0 && !was_changed && !rec_last)
        else $error("byte item carries record fields");

    a_rec_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rec_kind == tppr_pkg::KIND_REC |-> rec_last && out_byte == 8'd0)
        else $error("record item malformed");

    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && pkt_last |=> in_stall)
        else $error("input taken before packet record");

endmodule

bind tcp_payload_pattern_rewriter tppr_checker u_tppr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pkt_last     (pkt_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rec_kind     (rec_kind),
    .out_byte     (out_byte),
    .new_checksum (new_checksum),
    .was_changed  (was_changed),
    .rec_last     (rec_last)
);
